### rtl/bpa_pkg.sv
// Shared constants, codes and types of the bump pointer allocator.
`timescale 1ns / 1ps

package bpa_pkg;

  // Address space width; the region end is capped at 2^min(ADDR_WIDTH, 32).
  localparam int ADDR_WIDTH = 32;
  localparam int CAP_BITS   = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;

  // Field widths.
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 3;
  localparam int ALIGN_W   = 4;
  localparam int CFG_IDX_W = 1;

  // Pointer width holds base plus offset; sum width holds pointer plus pad plus size.
  localparam int PTR_W = DATA_W + 1;
  localparam int SUM_W = DATA_W + 3;
  localparam int PAD_W = (1 << ALIGN_W) - 1;

  localparam logic [PTR_W-1:0] REGION_CAP = PTR_W'(1) << CAP_BITS;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ALIGN   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESET   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REWIND  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REALLOC = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DATA_W-1:0]  req_size;
    logic [ALIGN_W-1:0] align_log2;
    logic [DATA_W-1:0]  old_addr;
    logic [DATA_W-1:0]  rewind_count;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] addr;
    logic              ok;
    logic [DATA_W-1:0] bytes_used;
  } rsp_t;

  // Allocator state as seen by the request logic.
  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] used;
    logic [DATA_W-1:0] last;
    logic [PTR_W-1:0]  cur;
    logic [PTR_W-1:0]  region_end;
  } state_t;

  // State update produced by one request.
  typedef struct packed {
    logic              we;
    logic [DATA_W-1:0] used;
    logic [DATA_W-1:0] last;
    logic [PTR_W-1:0]  cur;
  } upd_t;

endpackage

### rtl/bpa_intf.sv
// Request and response channel interfaces of the bump pointer allocator.
`timescale 1ns / 1ps

interface bpa_req_if;
  logic                        valid;
  logic                        ready;
  logic [bpa_pkg::KIND_W-1:0]  kind;
  logic [bpa_pkg::DATA_W-1:0]  req_size;
  logic [bpa_pkg::ALIGN_W-1:0] align_log2;
  logic [bpa_pkg::DATA_W-1:0]  old_addr;
  logic [bpa_pkg::DATA_W-1:0]  rewind_count;

  modport source (output valid, kind, req_size, align_log2, old_addr, rewind_count,
                  input ready);
  modport sink   (input valid, kind, req_size, align_log2, old_addr, rewind_count,
                  output ready);
endinterface

interface bpa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bpa_pkg::DATA_W-1:0] addr;
  logic                       ok;
  logic [bpa_pkg::DATA_W-1:0] bytes_used;

  modport source (output valid, addr, ok, bytes_used, input ready);
  modport sink   (input valid, addr, ok, bytes_used, output ready);
endinterface

### rtl/bump_pointer_allocator_unit.sv
// A request beat passes through the request register and then the response register.
// Throughput: one request per cycle while responses are taken; the request register feeds
// one pass of logic (pad, a three-input add and the region-end compare) into the response register.
// Reset (synchronous, active high) clears both registers' valid flags, the
// configuration registers and the allocator state to zero.
`timescale 1ns / 1ps

module bump_pointer_allocator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::DATA_W-1:0]    cfg_data,
  bpa_req_if.sink                       req,
  bpa_rsp_if.source                     rsp
);

  bpa_pkg::req_t   req_q;
  logic            req_valid;
  bpa_pkg::rsp_t   rsp_q;
  logic            rsp_valid;
  bpa_pkg::rsp_t   rsp_next;
  bpa_pkg::upd_t   upd;
  bpa_pkg::state_t st;
  logic            move;

  // A request moves on when the response register is empty or being drained.
  assign move      = req_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !req_valid || move;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req.ready) begin
      req_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      req_q.kind         <= req.kind;
      req_q.req_size     <= req.req_size;
      req_q.align_log2   <= req.align_log2;
      req_q.old_addr     <= req.old_addr;
      req_q.rewind_count <= req.rewind_count;
    end
  end

  bpa_exec u_exec (
    .req (req_q),
    .st  (st),
    .rsp (rsp_next),
    .upd (upd)
  );

  bpa_state u_state (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .apply     (move),
    .upd       (upd),
    .st        (st)
  );

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (move) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.addr       = rsp_q.addr;
  assign rsp.ok         = rsp_q.ok;
  assign rsp.bytes_used = rsp_q.bytes_used;

  a_move_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    move |=> rsp_valid)
    else $error("processed request did not produce a response beat");

  a_fail_addr_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_q.ok |-> rsp_q.addr == '0)
    else $error("rejected request returned a nonzero address");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    req_valid && rsp_valid && !rsp.ready |-> !req.ready)
    else $error("request taken while both registers are held");

endmodule

### rtl/bpa_exec.sv
// Request logic: computes the result and the state update for one request.
`timescale 1ns / 1ps

module bpa_exec (
  input  bpa_pkg::req_t   req,
  input  bpa_pkg::state_t st,
  output bpa_pkg::rsp_t   rsp,
  output bpa_pkg::upd_t   upd
);

  logic [bpa_pkg::PAD_W-1:0]  mask;
  logic [bpa_pkg::PAD_W-1:0]  pad;
  logic [bpa_pkg::SUM_W-1:0]  end_w;
  logic [bpa_pkg::SUM_W-1:0]  al;
  logic [bpa_pkg::SUM_W-1:0]  csum;
  logic [bpa_pkg::SUM_W-1:0]  usum;
  logic [bpa_pkg::SUM_W-1:0]  gsum;
  logic [bpa_pkg::PTR_W-1:0]  cur_alloc;
  logic                       wrap;
  logic                       alloc_fit;
  logic                       align_fit;
  logic                       grow_fit;
  logic                       match;
  logic                       alloc_path;

  // Alignment pad is the distance from the pointer to the next boundary.
  assign mask  = ~({bpa_pkg::PAD_W{1'b1}} << req.align_log2);
  assign pad   = (~st.cur[bpa_pkg::PAD_W-1:0] + bpa_pkg::PAD_W'(1)) & mask;
  assign end_w = bpa_pkg::SUM_W'(st.region_end);

  // Aligned pointer, end of a new block and the used count after it.
  assign al   = bpa_pkg::SUM_W'(st.cur) + bpa_pkg::SUM_W'(pad);
  assign csum = bpa_pkg::SUM_W'(st.cur) + bpa_pkg::SUM_W'(pad)
              + bpa_pkg::SUM_W'(req.req_size);
  assign usum = bpa_pkg::SUM_W'(st.used) + bpa_pkg::SUM_W'(pad)
              + bpa_pkg::SUM_W'(req.req_size);

  // A used count that reaches the full 32-bit range folds to zero, and so does the pointer.
  assign wrap      = |usum[bpa_pkg::SUM_W-1:bpa_pkg::DATA_W];
  assign cur_alloc = wrap ? {1'b0, csum[bpa_pkg::DATA_W-1:0]} : csum[bpa_pkg::PTR_W-1:0];

  assign alloc_fit = (csum <= end_w);
  assign align_fit = (al < end_w);

  // In-place growth applies to the last block when it is aligned.
  assign match = (bpa_pkg::PTR_W'(req.old_addr) + bpa_pkg::PTR_W'(st.last) == st.cur)
              && ((req.old_addr[bpa_pkg::PAD_W-1:0] & mask) == '0);
  assign gsum  = bpa_pkg::SUM_W'(st.cur) + bpa_pkg::SUM_W'(req.req_size)
               - bpa_pkg::SUM_W'(st.last);
  assign grow_fit = (req.req_size >= st.last) && (gsum < end_w);

  assign alloc_path = (req.kind == bpa_pkg::KIND_ALLOC)
                   || ((req.kind == bpa_pkg::KIND_REALLOC)
                       && ((req.old_addr == '0) || !match));

  // Result and state update per request kind.
  always_comb begin
    rsp.addr       = '0;
    rsp.ok         = 1'b0;
    upd.we         = 1'b0;
    upd.used       = st.used;
    upd.last       = st.last;
    upd.cur        = st.cur;
    if (alloc_path) begin
      if (alloc_fit) begin
        rsp.ok   = 1'b1;
        rsp.addr = al[bpa_pkg::DATA_W-1:0];
        upd.we   = 1'b1;
        upd.used = usum[bpa_pkg::DATA_W-1:0];
        upd.last = req.req_size;
        upd.cur  = cur_alloc;
      end
    end else begin
      case (req.kind)
        bpa_pkg::KIND_ALIGN: begin
          if (align_fit) begin
            rsp.ok   = 1'b1;
            rsp.addr = al[bpa_pkg::DATA_W-1:0];
            upd.we   = 1'b1;
            upd.used = st.used + bpa_pkg::DATA_W'(pad);
            upd.cur  = al[bpa_pkg::PTR_W-1:0];
          end
        end
        bpa_pkg::KIND_RESET: begin
          rsp.ok   = 1'b1;
          upd.we   = 1'b1;
          upd.used = '0;
          upd.cur  = bpa_pkg::PTR_W'(st.base);
        end
        bpa_pkg::KIND_REWIND: begin
          if (req.rewind_count <= st.used) begin
            rsp.ok   = 1'b1;
            upd.we   = 1'b1;
            upd.used = req.rewind_count;
            upd.cur  = bpa_pkg::PTR_W'(st.base) + bpa_pkg::PTR_W'(req.rewind_count);
          end
        end
        bpa_pkg::KIND_REALLOC: begin
          // Only the in-place case reaches here.
          if (grow_fit) begin
            rsp.ok   = 1'b1;
            rsp.addr = req.old_addr;
            upd.we   = 1'b1;
            upd.used = st.used + req.req_size - st.last;
            upd.last = req.req_size;
            upd.cur  = gsum[bpa_pkg::PTR_W-1:0];
          end
        end
        default: begin
          rsp.ok = 1'b0;
        end
      endcase
    end
    rsp.bytes_used = upd.used;
  end

endmodule

### rtl/bpa_state.sv
// Configuration registers and allocator state of the bump pointer allocator.
`timescale 1ns / 1ps

module bpa_state (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::DATA_W-1:0]    cfg_data,
  input  logic                          apply,
  input  bpa_pkg::upd_t                 upd,
  output bpa_pkg::state_t               st
);

  logic [bpa_pkg::DATA_W-1:0] base;
  logic [bpa_pkg::DATA_W-1:0] region;
  logic [bpa_pkg::DATA_W-1:0] used;
  logic [bpa_pkg::DATA_W-1:0] last;
  logic [bpa_pkg::PTR_W-1:0]  cur;
  logic [bpa_pkg::PTR_W-1:0]  region_end;
  logic [bpa_pkg::PTR_W-1:0]  end_sum;
  logic [bpa_pkg::PTR_W-1:0]  region_end_next;

  // Region end is the capped sum of base and size, registered off the request path.
  assign end_sum         = bpa_pkg::PTR_W'(base) + bpa_pkg::PTR_W'(region);
  assign region_end_next = (end_sum < bpa_pkg::REGION_CAP) ? end_sum : bpa_pkg::REGION_CAP;

  // Register writes start an empty region; otherwise take the request update.
  always_ff @(posedge clk) begin
    if (rst) begin
      base       <= '0;
      region     <= '0;
      used       <= '0;
      last       <= '0;
      cur        <= '0;
      region_end <= '0;
    end else begin
      region_end <= region_end_next;
      if (cfg_we) begin
        used <= '0;
        last <= '0;
        case (cfg_index)
          bpa_pkg::CFG_BASE: begin
            base <= cfg_data;
            cur  <= bpa_pkg::PTR_W'(cfg_data);
          end
          bpa_pkg::CFG_REGION: begin
            region <= cfg_data;
            cur    <= bpa_pkg::PTR_W'(base);
          end
          default: begin
            cur <= bpa_pkg::PTR_W'(base);
          end
        endcase
      end else if (apply && upd.we) begin
        used <= upd.used;
        last <= upd.last;
        cur  <= upd.cur;
      end
    end
  end

  assign st.base       = base;
  assign st.used       = used;
  assign st.last       = last;
  assign st.cur        = cur;
  assign st.region_end = region_end;

  // The pointer register always tracks base plus used count.
  a_cur_tracks: assert property (@(posedge clk) disable iff (rst)
    cur == bpa_pkg::PTR_W'(base) + bpa_pkg::PTR_W'(used))
    else $error("pointer does not equal base plus used count");

endmodule

### tb/tb.sv
// Self-checking testbench for the bump pointer allocator unit.
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_PCT      = 32;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 8;
  localparam int MAX_PRINTS    = 30;

  // Kind codes the block does not define; it must answer them with a rejection.
  localparam logic [bpa_pkg::KIND_W-1:0] KIND_BAD_FIRST = 3'd5;
  localparam logic [bpa_pkg::KIND_W-1:0] KIND_BAD_LAST  = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                          cfg_we;
  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bpa_pkg::DATA_W-1:0]    cfg_data;

  bpa_req_if req();
  bpa_rsp_if rsp();

  bump_pointer_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Allocator state as the testbench expects it to be.
  logic [bpa_pkg::DATA_W-1:0] region_base;
  logic [bpa_pkg::DATA_W-1:0] region_size;
  logic [bpa_pkg::DATA_W-1:0] used_bytes;
  logic [bpa_pkg::DATA_W-1:0] last_size;

  bpa_pkg::rsp_t expected_rsp[$];
  int   err_count    = 0;
  int   results_seen = 0;
  int   grants_seen  = 0;
  int   region_count = 0;
  int   kind_count[8];
  logic no_idle      = 1'b0;
  int   hold_req     = 0;

  function automatic bpa_pkg::req_t make_req(input logic [bpa_pkg::KIND_W-1:0] kind,
                                             input logic [bpa_pkg::DATA_W-1:0] size,
                                             input logic [bpa_pkg::ALIGN_W-1:0] align,
                                             input logic [bpa_pkg::DATA_W-1:0] old,
                                             input logic [bpa_pkg::DATA_W-1:0] rewind);
    bpa_pkg::req_t r;
    r.kind         = kind;
    r.req_size     = size;
    r.align_log2   = align;
    r.old_addr     = old;
    r.rewind_count = rewind;
    return r;
  endfunction

  // Address of the most recent block, as an in-place realloc must name it.
  function automatic logic [bpa_pkg::DATA_W-1:0] last_block_addr();
    return region_base + used_bytes - last_size;
  endfunction

  // Sizes are mostly small so that a region holds many blocks.
  function automatic logic [bpa_pkg::DATA_W-1:0] rand_size();
    if ($urandom_range(99) < 5) return $urandom;
    return $urandom & ((32'd1 << $urandom_range(0, 10)) - 32'd1);
  endfunction

  // Mostly well-formed requests built on the current state, with some noise.
  function automatic bpa_pkg::req_t random_request();
    bpa_pkg::req_t r;
    int unsigned   pick;
    r = make_req(bpa_pkg::KIND_ALLOC, rand_size(), 4'($urandom_range(0, 5)), $urandom,
                 $urandom);
    if ($urandom_range(9) == 0) r.align_log2 = 4'($urandom_range(0, 15));
    pick = $urandom_range(99);
    if (pick < 35) begin
      r.kind = bpa_pkg::KIND_ALLOC;
    end else if (pick < 55) begin
      r.kind       = bpa_pkg::KIND_REALLOC;
      r.old_addr   = last_block_addr();
      r.align_log2 = 4'($urandom_range(0, 3));
      if ($urandom_range(99) < 15 && last_size != 0)
        r.req_size = last_size - bpa_pkg::DATA_W'($urandom_range(1, 8));
      else
        r.req_size = last_size + bpa_pkg::DATA_W'($urandom_range(0, 64));
    end else if (pick < 62) begin
      r.kind     = bpa_pkg::KIND_REALLOC;
      r.old_addr = '0;
    end else if (pick < 67) begin
      r.kind = bpa_pkg::KIND_REALLOC;
    end else if (pick < 75) begin
      r.kind = bpa_pkg::KIND_ALIGN;
    end else if (pick < 85) begin
      r.kind = bpa_pkg::KIND_REWIND;
      if ($urandom_range(99) < 75)
        r.rewind_count = bpa_pkg::DATA_W'($urandom_range(0, used_bytes));
      else if ($urandom_range(1) == 0)
        r.rewind_count = used_bytes + bpa_pkg::DATA_W'($urandom_range(1, 16));
    end else if (pick < 90) begin
      r.kind = bpa_pkg::KIND_RESET;
    end else if (pick < 93) begin
      r.kind = bpa_pkg::KIND_W'($urandom_range(KIND_BAD_FIRST, KIND_BAD_LAST));
    end else begin
      r = make_req(bpa_pkg::KIND_W'($urandom_range(0, 7)), $urandom,
                   4'($urandom_range(0, 15)), $urandom, $urandom);
    end
    return r;
  endfunction

  // Expected response of one request; updates the expected state.
  // Sums are formed at 64 bits so that nothing wraps.
  task automatic predict_result(input bpa_pkg::req_t r, output bpa_pkg::rsp_t res);
    logic [63:0] cur, mask, aligned, lim, grow;
    logic        take, alloc_needed, hit;
    lim = {32'd0, region_base} + {32'd0, region_size};
    if (lim > (64'd1 << bpa_pkg::CAP_BITS)) lim = 64'd1 << bpa_pkg::CAP_BITS;
    cur          = {32'd0, region_base} + {32'd0, used_bytes};
    mask         = (64'd1 << r.align_log2) - 64'd1;
    aligned      = (cur + mask) & ~mask;
    take         = 1'b0;
    alloc_needed = 1'b0;
    res          = '0;
    case (r.kind)
      bpa_pkg::KIND_ALLOC: alloc_needed = 1'b1;
      bpa_pkg::KIND_ALIGN: begin
        if (aligned < lim) begin
          used_bytes = bpa_pkg::DATA_W'(aligned - region_base);
          res.addr   = bpa_pkg::DATA_W'(aligned);
          take       = 1'b1;
        end
      end
      bpa_pkg::KIND_RESET: begin
        used_bytes = '0;
        take       = 1'b1;
      end
      bpa_pkg::KIND_REWIND: begin
        if (r.rewind_count <= used_bytes) begin
          used_bytes = r.rewind_count;
          take       = 1'b1;
        end
      end
      bpa_pkg::KIND_REALLOC: begin
        if (r.old_addr == '0) begin
          alloc_needed = 1'b1;
        end else begin
          hit = (cur >= last_size) && (cur - last_size == r.old_addr) &&
                ((r.old_addr & mask[bpa_pkg::DATA_W-1:0]) == '0);
          if (!hit) begin
            alloc_needed = 1'b1;
          end else if (r.req_size >= last_size) begin
            // Grow the last block in place; a shrink is rejected.
            grow = r.req_size - last_size;
            if (grow + cur < lim) begin
              last_size  = r.req_size;
              used_bytes = used_bytes + bpa_pkg::DATA_W'(grow);
              res.addr   = r.old_addr;
              take       = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    if (alloc_needed && aligned + r.req_size <= lim) begin
      used_bytes = bpa_pkg::DATA_W'(aligned + r.req_size - region_base);
      last_size  = r.req_size;
      res.addr   = bpa_pkg::DATA_W'(aligned);
      take       = 1'b1;
    end
    res.ok = take;
    if (!take) res.addr = '0;
    res.bytes_used = used_bytes;
  endtask

  task automatic report_mismatch(input string what,
                                 input logic [bpa_pkg::DATA_W-1:0] got,
                                 input logic [bpa_pkg::DATA_W-1:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("[%0t] %s mismatch: got %h, expected %h", $time, what, got, want);
  endtask

  // Offer one request beat and record its expected response once accepted.
  // Valid is left high after the beat so that back-to-back beats need no toggle.
  task automatic send_req(input bpa_pkg::req_t r);
    bpa_pkg::rsp_t want;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.kind         <= r.kind;
    req.req_size     <= r.req_size;
    req.align_log2   <= r.align_log2;
    req.old_addr     <= r.old_addr;
    req.rewind_count <= r.rewind_count;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_result(r, want);
    expected_rsp.push_back(want);
    kind_count[r.kind]++;
  endtask

  // Stop offering requests and wait until every response has come back.
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A register write also empties the region.
  task automatic write_cfg(input logic [bpa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bpa_pkg::DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == bpa_pkg::CFG_BASE) region_base = value;
    else region_size = value;
    used_bytes = '0;
    last_size  = '0;
  endtask

  task automatic set_region(input logic [bpa_pkg::DATA_W-1:0] base,
                            input logic [bpa_pkg::DATA_W-1:0] size);
    drain();
    write_cfg(bpa_pkg::CFG_BASE, base);
    write_cfg(bpa_pkg::CFG_REGION, size);
    region_count++;
  endtask

  // Every kind, the rejections and the edges of the address space.
  task automatic test_directed();
    set_region(32'h0000_1000, 32'h0000_0100);
    send_req(make_req(bpa_pkg::KIND_ALLOC, 32'd0, 4'd0, 32'd0, 32'd0));
    send_req(make_req(bpa_pkg::KIND_ALLOC, 32'h10, 4'd4, 32'd0, 32'd0));
    // Grow in place, then try to shrink, then name it with too coarse an alignment.
    send_req(make_req(bpa_pkg::KIND_REALLOC, 32'h20, 4'd4, last_block_addr(), 32'd0));
    send_req(make_req(bpa_pkg::KIND_REALLOC, 32'h8, 4'd4, last_block_addr(), 32'd0));
    send_req(make_req(bpa_pkg::KIND_REALLOC, 32'h8, 4'd15, last_block_addr(), 32'd0));
    // No old block, an older block and an address outside the region all allocate anew.
    send_req(make_req(bpa_pkg::KIND_REALLOC, 32'h8, 4'd3, 32'd0, 32'd0));
    send_req(make_req(bpa_pkg::KIND_REALLOC, 32'h4, 4'd2, 32'h0000_1000, 32'd0));
    send_req(make_req(bpa_pkg::KIND_REALLOC, 32'h4, 4'd2, 32'hDEAD_0000, 32'd0));
    send_req(make_req(bpa_pkg::KIND_REALLOC, last_size + 32'h100, 4'd0, last_block_addr(),
                      32'd0));
    send_req(make_req(bpa_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 4'd0, 32'd0, 32'd0));
    send_req(make_req(bpa_pkg::KIND_ALIGN, 32'd0, 4'd3, 32'd0, 32'd0));
    send_req(make_req(bpa_pkg::KIND_ALIGN, 32'd0, 4'd15, 32'd0, 32'd0));
    // Fill the region exactly, then align and allocate at its end.
    send_req(make_req(bpa_pkg::KIND_ALLOC, region_size - used_bytes, 4'd0, 32'd0, 32'd0));
    send_req(make_req(bpa_pkg::KIND_ALIGN, 32'd0, 4'd0, 32'd0, 32'd0));
    send_req(make_req(bpa_pkg::KIND_ALLOC, 32'd0, 4'd0, 32'd0, 32'd0));
    send_req(make_req(bpa_pkg::KIND_REWIND, 32'd0, 4'd0, 32'd0, used_bytes + 32'd1));
    send_req(make_req(bpa_pkg::KIND_REWIND, 32'd0, 4'd0, 32'd0, 32'h18));
    send_req(make_req(bpa_pkg::KIND_REWIND, 32'd0, 4'd0, 32'd0, 32'hFFFF_FFFF));
    send_req(make_req(bpa_pkg::KIND_RESET, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF));
    for (int k = KIND_BAD_FIRST; k <= KIND_BAD_LAST; k++)
      send_req(make_req(bpa_pkg::KIND_W'(k), 32'd4, 4'd0, 32'd0, 32'd0));
    // Region at the top of the address space: the end is capped.
    set_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(make_req(bpa_pkg::KIND_ALLOC, 32'd1, 4'd0, 32'd0, 32'd0));
    send_req(make_req(bpa_pkg::KIND_REALLOC, 32'd1, 4'd0, last_block_addr(), 32'd0));
    send_req(make_req(bpa_pkg::KIND_ALLOC, 32'd0, 4'd0, 32'd0, 32'd0));
    // Base zero: a granted block may sit at address zero.
    set_region(32'h0, 32'hFFFF_FFFF);
    send_req(make_req(bpa_pkg::KIND_ALLOC, 32'd0, 4'd0, 32'd0, 32'd0));
    send_req(make_req(bpa_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 4'd0, 32'd0, 32'd0));
  endtask

  // Random traffic over several regions, the extremes among them.
  task automatic test_region_sweep();
    logic [bpa_pkg::DATA_W-1:0] bases [7];
    logic [bpa_pkg::DATA_W-1:0] sizes [7];
    int                         counts [7];
    bases  = '{32'h0000_1000, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h8000_0000, 32'h0};
    sizes  = '{32'h0000_1000, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0002_0000,
               32'h0000_4000, 32'h0};
    counts = '{260, 60, 240, 150, 200, 240, 240};
    bases[6] = $urandom & 32'hFFFF_F000;
    sizes[6] = bpa_pkg::DATA_W'($urandom_range(0, 32'h0001_0000));
    for (int p = 0; p < 7; p++) begin
      set_region(bases[p], sizes[p]);
      repeat (counts[p]) send_req(random_request());
    end
  endtask

  // The response side holds off while requests keep coming, so the block
  // fills and stalls its input; then the sender waits for every response.
  task automatic test_backpressure();
    set_region(32'h0000_4000, 32'h0000_0800);
    no_idle = 1'b1;
    hold_req++;
    repeat (100) send_req(random_request());
    no_idle = 1'b0;
    drain();
  endtask

  // A long stretch at full rate on both sides.
  task automatic test_full_rate();
    set_region(32'h0000_0010, 32'h0000_3000);
    no_idle = 1'b1;
    repeat (220) send_req(random_request());
    no_idle = 1'b0;
  endtask

  // Response side: checks each response beat and drives ready.
  initial begin : result_checker
    bpa_pkg::rsp_t want;
    int            hold_left;
    int            hold_ack;
    rsp.ready = 1'b0;
    hold_left = 0;
    hold_ack  = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected beat, addr", rsp.addr, '0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.addr !== want.addr) report_mismatch("addr", rsp.addr, want.addr);
          if (rsp.ok !== want.ok)
            report_mismatch("ok", bpa_pkg::DATA_W'(rsp.ok), bpa_pkg::DATA_W'(want.ok));
          if (rsp.bytes_used !== want.bytes_used)
            report_mismatch("bytes_used", rsp.bytes_used, want.bytes_used);
          results_seen++;
          if (want.ok) grants_seen++;
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= !rst && (no_idle || $urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Ends the run when no beat moves on either side for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Test sequence.
  initial begin
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    req.valid        = 1'b0;
    req.kind         = '0;
    req.req_size     = '0;
    req.align_log2   = '0;
    req.old_addr     = '0;
    req.rewind_count = '0;
    region_base      = '0;
    region_size      = '0;
    used_bytes       = '0;
    last_size        = '0;
    foreach (kind_count[k]) kind_count[k] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_region_sweep();
    test_backpressure();
    test_full_rate();

    drain();
    repeat (END_CYCLES) @(posedge clk);
    $display("Covered %0d alloc, %0d align, %0d reset, %0d rewind, %0d realloc, %0d bad kind",
             kind_count[bpa_pkg::KIND_ALLOC], kind_count[bpa_pkg::KIND_ALIGN],
             kind_count[bpa_pkg::KIND_RESET], kind_count[bpa_pkg::KIND_REWIND],
             kind_count[bpa_pkg::KIND_REALLOC],
             kind_count[5] + kind_count[6] + kind_count[7]);
    $display("%0d responses checked, %0d granted, over %0d region settings",
             results_seen, grants_seen, region_count);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
